FILE: rtl/lkv_pkg.sv
// Package for the LRU key-value cache: field widths, opcode codes and the
// request record passed from the front queue to the lookup engine.
// No dependencies.
package lkv_pkg;

   localparam int KEY_W     = 32;
   localparam int VAL_W     = 31;
   localparam int CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } req_type;

endpackage

FILE: rtl/lkv_if.sv
// Valid/ready channel interfaces for the LRU key-value cache: request and
// response transactions. Depends on lkv_pkg.
interface lkv_req_if;
   import lkv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [KEY_W-1:0]  lookup_key;
   logic        [VAL_W-1:0]  write_value;

   modport source (output valid, output opcode, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_key, input write_value,
                   output ready);
endinterface

interface lkv_rsp_if;
   import lkv_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [VAL_W-1:0]  read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

FILE: rtl/lkv_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
// No dependencies.
module lkv_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/lkv_front.sv
// Front end of the LRU key-value cache: accepts request transactions into a
// two-entry queue and presents the oldest one, decoded, to the engine.
// Depends on lkv_pkg and lkv_if.
module lkv_front (
   input  logic            clock,
   input  logic            reset,
   lkv_req_if.sink         req_chan,
   output logic            head_valid,
   output lkv_pkg::req_type head,
   input  logic            head_pop
);
   import lkv_pkg::*;

   req_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;
   req_type     incoming;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign pop            = head_pop && (count_ff != 2'd0);
   assign head_valid     = (count_ff != 2'd0);
   assign head           = slot_ff[rd_ptr_ff];

   always_comb begin
      incoming.opcode = (req_chan.opcode == 1'b1) ? OP_SET : OP_GET;
      incoming.key    = req_chan.lookup_key;
      incoming.value  = req_chan.write_value;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end
endmodule

FILE: rtl/lkv_engine.sv
// Back end of the LRU key-value cache: parallel key match, recency ranks,
// replacement choice, value RAM and the response register.
// Depends on lkv_pkg, lkv_if and lkv_ram.
module lkv_engine #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lkv_pkg::CAP_W-1:0]  capacity,
   input  logic                       head_valid,
   input  lkv_pkg::req_type           head,
   output logic                       head_pop,
   lkv_rsp_if.source                  rsp_chan
);
   import lkv_pkg::*;

   localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff [ENTRIES];
   logic [AW-1:0]      age_ff [ENTRIES];
   logic [AW-1:0]      age_in [ENTRIES];
   logic [OW-1:0]      occ_ff, occ_in;

   logic               b_valid_ff, b_valid_in;
   logic               b_hit_ff, b_hit_in;
   logic               b_read_ff, b_read_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic               fire;
   logic               b_adv;
   logic [ENTRIES-1:0] match;
   logic               hit;
   logic [AW-1:0]      found_idx;
   logic [AW-1:0]      found_age;
   logic [AW-1:0]      free_idx;
   logic [AW-1:0]      victim_idx;
   logic [AW-1:0]      oldest_age;
   logic [CMPW-1:0]    eff_cap;
   logic               room;
   logic               is_set;
   logic               touch;
   logic               insert;
   logic               replace;
   logic [AW-1:0]      sel_idx;
   logic [AW-1:0]      limit;
   logic [VAL_W-1:0]   ram_rd_data;

   assign b_adv    = b_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign fire     = head_valid && (!b_valid_ff || b_adv);
   assign head_pop = fire;
   assign is_set   = (head.opcode == OP_SET);

   // Parallel lookup; keys among valid entries are unique, so OR-encode the match.
   always_comb begin
      found_idx = '0;
      found_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == head.key);
         if (match[i]) begin
            found_idx = found_idx | AW'(i);
            found_age = found_age | age_ff[i];
         end
      end
      hit = |match;
   end

   // Ranks of valid entries form a permutation, so the oldest holds occupancy - 1.
   always_comb begin
      oldest_age = AW'(occ_ff - OW'(1));
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && (age_ff[i] == oldest_age)) begin
            victim_idx = victim_idx | AW'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = AW'(i);
         end
      end
   end

   always_comb begin
      if (capacity == '0) begin
         eff_cap = CMPW'(1);
      end else if (CMPW'(capacity) > CMPW'(ENTRIES)) begin
         eff_cap = CMPW'(ENTRIES);
      end else begin
         eff_cap = CMPW'(capacity);
      end
      room = CMPW'(occ_ff) < eff_cap;
   end

   always_comb begin
      touch   = fire && (hit || is_set);
      insert  = fire && !hit && is_set && room;
      replace = fire && !hit && is_set && !room;
      if (hit) begin
         sel_idx = found_idx;
         limit   = found_age;
      end else if (room) begin
         sel_idx = free_idx;
         limit   = '0;
      end else begin
         sel_idx = victim_idx;
         limit   = oldest_age;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (touch) begin
            if (sel_idx == AW'(i)) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && (insert || (age_ff[i] < limit))) begin
               age_in[i] = age_ff[i] + AW'(1);
            end
         end
      end
      if (insert) begin
         valid_in[sel_idx] = 1'b1;
         occ_in            = occ_ff + OW'(1);
      end
   end

   always_comb begin
      b_valid_in = fire ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      b_hit_in   = fire ? hit : b_hit_ff;
      b_read_in  = fire ? (hit && !is_set) : b_read_ff;

      rsp_valid_in = b_adv || (rsp_valid_ff && !rsp_chan.ready);
      rsp_hit_in   = b_adv ? b_hit_ff : rsp_hit_ff;
      if (b_adv) begin
         rsp_value_in = b_read_ff ? ram_rd_data : '0;
      end else begin
         rsp_value_in = rsp_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      b_hit_ff     <= b_hit_in;
      b_read_ff    <= b_read_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      if (insert || replace) begin
         key_ff[sel_idx] <= head.key;
      end
   end

   lkv_ram #(
      .WIDTH (VAL_W),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (touch && is_set),
      .wr_addr (sel_idx),
      .wr_data (head.value),
      .rd_en   (fire && hit && !is_set),
      .rd_addr (found_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;
endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: capacity register, front queue and
// lookup engine. Depends on lkv_pkg, lkv_if, lkv_front and lkv_engine.
//
// Fully associative cache of ENTRIES key-value pairs with least-recently-used
// replacement. Every request (get or set) yields one response: hit tells
// whether the key was held before the request, read_value carries the stored
// value on a get that hits and zero otherwise. Throughput is one request per
// cycle while the response channel takes responses: all keys are compared and
// all recency ranks updated at once in the engine. An accepted request waits
// in the request queue, then is looked up, updated and its value RAM read in
// the engine's lookup stage, then its response waits in the response register.
// The capacity register limits how many entries fill before eviction starts;
// zero acts as one and values above ENTRIES act as ENTRIES. Write it only
// while no request is in flight; lowering it never flushes entries.
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   lkv_req_if.sink                    req_chan,
   lkv_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [lkv_pkg::CAP_W-1:0]  csr_write_data
);
   import lkv_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             head_valid;
   req_type          head;
   logic             head_pop;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   lkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   lkv_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );
endmodule
